// ----- src/dfec_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfec_pkg: shared definitions for the decimating FIR with edge clamping
// Widths, register indexes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dfec_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int COEF_W         = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int MAX_TAPS       = 16;
	localparam int MAX_DECIMATION = 16;
	localparam int COEF_WORDS     = 4;
	localparam int COEF_WORD_W    = 64;
	localparam int COEFS_PER_WORD = COEF_WORD_W / COEF_W;

	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int TAP_W       = $clog2(MAX_TAPS);
	localparam int PHASE_W     = $clog2(MAX_DECIMATION);
	localparam int LOOK_W      = $clog2(MAX_TAPS / 2);
	localparam int WARM_W      = 5;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int ACC_W       = PROD_W + TAP_W;

	localparam logic [WARM_W-1:0] WARM_MAX = {WARM_W{1'b1}};
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_TAPS   = 3'd0,
		CFG_DECIMATION = 3'd1,
		CFG_COEF_A     = 3'd2,
		CFG_COEF_B     = 3'd3,
		CFG_COEF_C     = 3'd4,
		CFG_COEF_D     = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FLUSH,
		ST_MAC,
		ST_DRAIN,
		ST_STORE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic adv;
		logic mac_start;
		logic use_flush;
		logic mac_issue;
		logic k_dec;
		logic store;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic ge_look;
		logic center_hit;
		logic k_zero;
		logic t_last;
		logic hold_valid;
		logic slot_free;
		logic is_last;
	} sts_t;

endpackage
`default_nettype wire

// ----- src/dfec_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfec_if: channel interfaces
// Sample input, result output and configuration write channels, each with
// valid and ready.
// ----------------------------------------------------------------------------
interface dfec_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dfec_pkg::SAMPLE_W-1:0] sample;
	logic                                 is_last;

	modport source(output valid, sample, is_last, input ready);
	modport sink(input valid, sample, is_last, output ready);
endinterface

interface dfec_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dfec_pkg::SAMPLE_W-1:0] filtered;
	logic                                 clipped;
	logic                                 run_last;
	logic                                 stream_end;

	modport source(output valid, filtered, clipped, run_last, stream_end, input ready);
	modport sink(input valid, filtered, clipped, run_last, stream_end, output ready);
endinterface

interface dfec_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [dfec_pkg::CFG_IDX_W-1:0]      index;
	logic [dfec_pkg::COEF_WORD_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/decimating_fir_edge_clamp_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// decimating_fir_edge_clamp_unit: decimating FIR filter with edge clamping
// Filters a stream of signed 16-bit samples with up to 16 Q2.14 taps and
// emits one saturated result per decimation period, flushing on the last
// sample of a stream.
//
//   channel  role    payload                                       
//   din      sink    sample, is_last                               
//   dout     source  filtered, clipped, run_last, stream_end       
//   cfg      sink    index, data (register write, always ready)    
//
// One shared multiplier evaluates the taps, one per cycle. Reset is
// asynchronous, active low, and needs no clearing pass. A stalled output
// only blocks the second result, so one new sample is taken while a
// result waits.
// ----------------------------------------------------------------------------
module decimating_fir_edge_clamp_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dfec_in_if.sink    din,
	dfec_out_if.source dout,
	dfec_cfg_if.sink   cfg
);

	dfec_pkg::cmd_t cmd;
	dfec_pkg::sts_t sts;
	logic           in_ready;

	assign din.ready = in_ready;

	dfec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	dfec_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_sample  (din.sample),
		.in_is_last (din.is_last),
		.cfg        (cfg),
		.dout       (dout)
	);

endmodule
`default_nettype wire

// ----- src/dfec_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfec_ctrl: sequencing controller
// Walks one input item through the centre checks, the flush indexes, the
// shared multiply-accumulate and the hand-off of results to the output.
// ----------------------------------------------------------------------------
module dfec_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output dfec_pkg::cmd_t      cmd,
	input  wire dfec_pkg::sts_t sts
);

	dfec_pkg::state_t state_q;
	dfec_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfec_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dfec_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = dfec_pkg::ST_CHECK;
			end
			dfec_pkg::ST_CHECK: begin
				if (sts.ge_look && sts.center_hit) begin
					state_nxt = dfec_pkg::ST_MAC;
				end else if (sts.is_last) begin
					state_nxt = dfec_pkg::ST_FLUSH;
				end else begin
					state_nxt = dfec_pkg::ST_FINISH;
				end
			end
			dfec_pkg::ST_FLUSH: begin
				if (sts.k_zero) begin
					state_nxt = dfec_pkg::ST_FINISH;
				end else if (sts.center_hit) begin
					state_nxt = dfec_pkg::ST_MAC;
				end
			end
			dfec_pkg::ST_MAC: begin
				if (sts.t_last) state_nxt = dfec_pkg::ST_DRAIN;
			end
			dfec_pkg::ST_DRAIN: begin
				state_nxt = dfec_pkg::ST_STORE;
			end
			dfec_pkg::ST_STORE: begin
				if (sts.slot_free) begin
					state_nxt = sts.is_last ? dfec_pkg::ST_FLUSH : dfec_pkg::ST_FINISH;
				end
			end
			dfec_pkg::ST_FINISH: begin
				if (sts.slot_free) state_nxt = dfec_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = dfec_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			dfec_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			dfec_pkg::ST_CHECK: begin
				if (sts.ge_look) begin
					cmd.adv       = 1'b1;
					cmd.mac_start = sts.center_hit;
				end
			end
			dfec_pkg::ST_FLUSH: begin
				if (!sts.k_zero) begin
					cmd.adv       = 1'b1;
					cmd.k_dec     = 1'b1;
					cmd.use_flush = 1'b1;
					cmd.mac_start = sts.center_hit;
				end
			end
			dfec_pkg::ST_MAC: begin
				cmd.mac_issue = 1'b1;
			end
			dfec_pkg::ST_STORE: begin
				cmd.store = 1'b1;
			end
			dfec_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == dfec_pkg::ST_CHECK))
		else $error("accepted sample did not start the centre check");

	a_drain_after_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfec_pkg::ST_DRAIN) |-> ($past(state_q) == dfec_pkg::ST_MAC))
		else $error("drain cycle without a preceding multiply-accumulate");

	a_store_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfec_pkg::ST_STORE) |->
		($past(state_q) == dfec_pkg::ST_DRAIN || $past(state_q) == dfec_pkg::ST_STORE))
		else $error("result stored without a finished accumulation");

	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfec_pkg::ST_FINISH && !sts.slot_free) |=>
		(state_q == dfec_pkg::ST_FINISH))
		else $error("finished an item while its last result was still held");
`endif

endmodule
`default_nettype wire

// ----- src/dfec_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfec_dpath: filter datapath
// Configuration registers, sample history, centre tracking, one shared
// multiplier with accumulator, result hold register and output register.
// ----------------------------------------------------------------------------
module dfec_dpath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire dfec_pkg::cmd_t                       cmd,
	output dfec_pkg::sts_t                            sts,
	input  wire logic signed [dfec_pkg::SAMPLE_W-1:0] in_sample,
	input  wire logic                                 in_is_last,
	dfec_cfg_if.sink                                  cfg,
	dfec_out_if.source                                dout
);

	localparam int SW = dfec_pkg::SAMPLE_W;
	localparam int TW = dfec_pkg::TAP_W;
	localparam int CW = dfec_pkg::CFG_W;
	localparam int LW = dfec_pkg::LOOK_W;
	localparam int PW = dfec_pkg::PHASE_W;
	localparam int WW = dfec_pkg::WARM_W;
	localparam int AW = dfec_pkg::ACC_W;
	localparam int FB = dfec_pkg::COEF_FRAC_BITS;

	// Configuration registers.
	logic [CW-1:0]                       num_taps_q;
	logic [CW-1:0]                       decimation_q;
	logic [dfec_pkg::COEF_WORD_W-1:0]    coef_q [dfec_pkg::COEF_WORDS];

	// Stream state.
	logic signed [SW-1:0] hist_q [dfec_pkg::MAX_TAPS];
	logic [WW-1:0]        warmup_q;
	logic [PW-1:0]        phase_q;
	logic                 started_q;
	logic                 ge_look_q;
	logic [LW-1:0]        k_q;
	logic                 is_last_q;

	// Multiply-accumulate.
	logic [LW-1:0]                    back_q;
	logic [TW-1:0]                    t_q;
	logic signed [dfec_pkg::PROD_W-1:0] prod_s1;
	logic                             prod_v_s1;
	logic signed [AW-1:0]             acc_q;

	// Held result and output register.
	logic signed [SW-1:0] hold_filt_q;
	logic                 hold_clip_q;
	logic                 hold_v_q;
	logic signed [SW-1:0] out_filt_q;
	logic                 out_clip_q;
	logic                 out_run_last_q;
	logic                 out_end_q;
	logic                 out_v_q;

	logic [CW-1:0]   taps_eff;
	logic [CW-1:0]   half_taps;
	logic [CW-1:0]   look_full;
	logic [LW-1:0]   look;
	logic [CW-1:0]   dec_eff;
	logic [CW-1:0]   half_dec;
	logic            center_hit;
	logic [PW:0]     phase_inc;
	logic [WW:0]     warm_inc;
	logic [LW-1:0]   k_init;
	logic [TW:0]     pos;
	logic [TW:0]     diff;
	logic [TW-1:0]   bidx;
	logic [dfec_pkg::COEF_WORD_W-1:0] coef_word;
	logic signed [dfec_pkg::COEF_W-1:0] coef_sel;
	logic signed [AW-1:0] q_floor;
	logic signed [AW-1:0] q_tz;
	logic            round_up;
	logic            in_range;
	logic signed [SW-1:0] res_filt;
	logic            res_clip;
	logic            can_move;
	logic            slot_free;
	logic            move_store;
	logic            move_finish;

	// Effective tap count, look-ahead and decimation.
	always_comb begin
		if (num_taps_q == '0) begin
			taps_eff = CW'(1);
		end else if (num_taps_q > CW'(dfec_pkg::MAX_TAPS)) begin
			taps_eff = CW'(dfec_pkg::MAX_TAPS);
		end else begin
			taps_eff = num_taps_q;
		end
		if (decimation_q == '0) begin
			dec_eff = CW'(1);
		end else if (decimation_q > CW'(dfec_pkg::MAX_DECIMATION)) begin
			dec_eff = CW'(dfec_pkg::MAX_DECIMATION);
		end else begin
			dec_eff = decimation_q;
		end
		half_taps = taps_eff >> 1;
		look_full = taps_eff - CW'(1) - half_taps;
		look      = look_full[LW-1:0];
		half_dec  = dec_eff >> 1;
	end

	// Before the first centre the phase counts up to decimation/2; after it,
	// the phase runs modulo the decimation and zero marks a centre.
	assign center_hit = started_q ? (phase_q == '0) : (CW'(phase_q) >= half_dec);
	assign phase_inc  = {1'b0, phase_q} + (PW+1)'(1);

	// Number of flush indexes still owed when this sample is the last one.
	assign warm_inc = {1'b0, warmup_q} + (WW+1)'(1);
	assign k_init   = (warm_inc < (WW+1)'(look)) ? warm_inc[LW-1:0] : look;

	// History index for tap t, clamped to the stored range.
	always_comb begin
		pos  = (TW+1)'(back_q) + (TW+1)'(half_taps);
		diff = pos - {1'b0, t_q};
		if (pos < {1'b0, t_q}) begin
			bidx = '0;
		end else if (diff > (TW+1)'(dfec_pkg::MAX_TAPS - 1)) begin
			bidx = TW'(dfec_pkg::MAX_TAPS - 1);
		end else begin
			bidx = diff[TW-1:0];
		end
	end

	assign coef_word = coef_q[t_q[TW-1:2]];
	assign coef_sel  = coef_word[{t_q[1:0], 4'b0000} +: dfec_pkg::COEF_W];

	// Scale down with truncation toward zero, then saturate.
	always_comb begin
		q_floor  = acc_q >>> FB;
		round_up = acc_q[AW-1] && (|acc_q[FB-1:0]);
		q_tz     = q_floor + {{(AW-1){1'b0}}, round_up};
		in_range = (&q_tz[AW-1:SW-1]) || !(|q_tz[AW-1:SW-1]);
		res_clip = !in_range;
		if (in_range) begin
			res_filt = q_tz[SW-1:0];
		end else if (q_tz[AW-1]) begin
			res_filt = dfec_pkg::SAT_MIN;
		end else begin
			res_filt = dfec_pkg::SAT_MAX;
		end
	end

	assign can_move    = !out_v_q || dout.ready;
	assign slot_free   = !hold_v_q || can_move;
	assign move_store  = cmd.store && hold_v_q && can_move;
	assign move_finish = cmd.finish && hold_v_q && can_move;

	// Configuration port.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q   <= CW'(1);
			decimation_q <= CW'(1);
			for (int i = 0; i < dfec_pkg::COEF_WORDS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				dfec_pkg::CFG_NUM_TAPS:   num_taps_q   <= cfg.data[CW-1:0];
				dfec_pkg::CFG_DECIMATION: decimation_q <= cfg.data[CW-1:0];
				dfec_pkg::CFG_COEF_A:     coef_q[0]    <= cfg.data;
				dfec_pkg::CFG_COEF_B:     coef_q[1]    <= cfg.data;
				dfec_pkg::CFG_COEF_C:     coef_q[2]    <= cfg.data;
				dfec_pkg::CFG_COEF_D:     coef_q[3]    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Sample history; the first sample of a stream fills every entry.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (warmup_q == '0) begin
				for (int i = 0; i < dfec_pkg::MAX_TAPS; i++) begin
					hist_q[i] <= in_sample;
				end
			end else begin
				for (int i = dfec_pkg::MAX_TAPS - 1; i > 0; i--) begin
					hist_q[i] <= hist_q[i-1];
				end
				hist_q[0] <= in_sample;
			end
		end
	end

	// Stream control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q  <= '0;
			phase_q   <= '0;
			started_q <= 1'b0;
			ge_look_q <= 1'b0;
			k_q       <= '0;
			is_last_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (warmup_q != dfec_pkg::WARM_MAX) warmup_q <= warmup_q + WW'(1);
				ge_look_q <= (warmup_q >= WW'(look));
				k_q       <= k_init;
				is_last_q <= in_is_last;
			end
			if (cmd.k_dec) k_q <= k_q - LW'(1);
			if (cmd.adv) begin
				if (!started_q) begin
					if (center_hit) begin
						started_q <= 1'b1;
						phase_q   <= (dec_eff > CW'(1)) ? PW'(1) : '0;
					end else begin
						phase_q <= phase_inc[PW-1:0];
					end
				end else if (CW'(phase_inc) >= dec_eff) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_inc[PW-1:0];
				end
			end
			// A flushed stream returns to its reset state.
			if (cmd.finish && slot_free && is_last_q) begin
				warmup_q  <= '0;
				phase_q   <= '0;
				started_q <= 1'b0;
			end
		end
	end

	// Shared multiplier with a registered product ahead of the accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
			t_q       <= '0;
		end else begin
			prod_v_s1 <= cmd.mac_issue;
			if (cmd.mac_start) begin
				t_q <= '0;
			end else if (cmd.mac_issue) begin
				t_q <= t_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_start) begin
			back_q <= cmd.use_flush ? (k_q - LW'(1)) : look;
		end
		if (cmd.mac_issue) begin
			prod_s1 <= hist_q[bidx] * coef_sel;
		end
		if (cmd.mac_start) begin
			acc_q <= '0;
		end else if (prod_v_s1) begin
			acc_q <= acc_q + AW'(prod_s1);
		end
	end

	// A result waits in the hold register until it is known whether another
	// result of the same sample follows it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.store && slot_free) begin
				hold_v_q <= 1'b1;
			end else if (move_finish) begin
				hold_v_q <= 1'b0;
			end
			if (move_store || move_finish) begin
				out_v_q <= 1'b1;
			end else if (dout.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && slot_free) begin
			hold_filt_q <= res_filt;
			hold_clip_q <= res_clip;
		end
		if (move_store || move_finish) begin
			out_filt_q     <= hold_filt_q;
			out_clip_q     <= hold_clip_q;
			out_run_last_q <= move_finish;
			out_end_q      <= move_finish && is_last_q;
		end
	end

	assign dout.valid      = out_v_q;
	assign dout.filtered   = out_filt_q;
	assign dout.clipped    = out_clip_q;
	assign dout.run_last   = out_run_last_q;
	assign dout.stream_end = out_end_q;

	always_comb begin
		sts.ge_look    = ge_look_q;
		sts.center_hit = center_hit;
		sts.k_zero     = (k_q == '0);
		sts.t_last     = (t_q == TW'(taps_eff - CW'(1)));
		sts.hold_valid = hold_v_q;
		sts.slot_free  = slot_free;
		sts.is_last    = is_last_q;
	end

endmodule
`default_nettype wire
